// ===== hdl/lupds_pkg.sv =====
// Shared types, constants and fixed-point helpers for the LUP solver.
package lupds_pkg;

  localparam int MAX_SIZE = 16;
  localparam int IDX_W    = $clog2(MAX_SIZE);
  localparam int DIM_W    = IDX_W + 1;
  localparam int MEM_AW   = 2 * IDX_W;

  localparam logic [63:0] SIGN64 = 64'h8000_0000_0000_0000;
  localparam logic [63:0] POSMAX = 64'h7FFF_FFFF_FFFF_FFFF;

  // Operations that the sequencer requests from the datapath.
  typedef enum logic [4:0] {
    DP_NOP,
    DP_LOAD_M,
    DP_LOAD_R,
    DP_BEST_CLR,
    DP_BEST_CMP,
    DP_FSING_CLR,
    DP_FSING_SET,
    DP_TMP_CAP,
    DP_WR_RDATA,
    DP_WR_TMP,
    DP_PIV_CAP,
    DP_DIV_F,
    DP_WR_F,
    DP_MUL_F,
    DP_CUR_CAP,
    DP_WR_UPD,
    DP_SERR_CLR,
    DP_ACC_CLR,
    DP_MUL_X,
    DP_ACC_ADD,
    DP_FWD_WR,
    DP_DIV_B,
    DP_SOL_WR,
    DP_EMIT_STAT,
    DP_EMIT_SOL
  } dp_op_t;

  typedef struct packed {
    dp_op_t           op;
    logic [IDX_W-1:0] rd_row;
    logic [IDX_W-1:0] rd_col;
    logic [IDX_W-1:0] wr_row;
    logic [IDX_W-1:0] wr_col;
    logic [IDX_W-1:0] xidx;
    logic [IDX_W-1:0] ridx;
    logic [IDX_W-1:0] res_index;
    logic             res_last;
    logic             force_sing;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic best_gt;
    logic best_zero;
    logic out_free;
  } dp_stat_t;

  // Magnitude of a two's complement value; the most negative value maps to 2^63.
  function automatic logic [63:0] mag64(input logic [63:0] v);
    mag64 = v[63] ? (64'd0 - v) : v;
  endfunction

  // Rebuild a saturated signed value from a magnitude and a sign.
  function automatic logic [63:0] sat_signed(input logic [63:0] m, input logic neg,
                                             input logic ovf);
    if (neg) begin
      sat_signed = (ovf || m > SIGN64) ? SIGN64 : (64'd0 - m);
    end else begin
      sat_signed = (ovf || m > POSMAX) ? POSMAX : m;
    end
  endfunction

  // Saturating addition.
  function automatic logic [63:0] sadd(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] r;
    r = a + b;
    if (a[63] == b[63] && r[63] != a[63]) begin
      sadd = a[63] ? SIGN64 : POSMAX;
    end else begin
      sadd = r;
    end
  endfunction

  // Saturating subtraction.
  function automatic logic [63:0] ssub(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] r;
    r = a - b;
    if (a[63] != b[63] && r[63] != a[63]) begin
      ssub = a[63] ? SIGN64 : POSMAX;
    end else begin
      ssub = r;
    end
  endfunction

endpackage

// ===== hdl/lup_decompose_and_solve.sv =====
// Top level of the LUP factor-and-solve block with its register port.
//
//  channel   direction  handshake            payload
//  input     in         in_valid / in_stall  operation, row, column, element_value, last
//  output    out        out_valid / out_stall kind, index, result_value, singular, last_res
//  config    in         APB write/read       size_in_use at byte address 0
//
// Factoring an n by n matrix runs through one sequencer; each elimination
// update uses the shared multiplier of four partial products, and each quotient
// the bit-serial divider. Reset is synchronous; no clearing pass is needed.
// A stalled output holds its result while the next load is already taken.
module lup_decompose_and_solve (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               operation,
  input  logic [3:0]         row,
  input  logic [3:0]         column,
  input  logic signed [63:0] element_value,
  input  logic               last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               kind,
  output logic [3:0]         index,
  output logic signed [63:0] result_value,
  output logic               singular,
  output logic               last_res,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import lupds_pkg::*;

  logic [4:0]       size_in_use;
  logic             cfg_we;
  logic [DIM_W-1:0] n;
  dp_cmd_t          cmd;
  dp_stat_t         stat;

  // Register port: one register, always ready.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : {27'd0, size_in_use};

  always_ff @(posedge clk) begin
    if (rst) begin
      size_in_use <= 5'd16;
    end else if (cfg_we) begin
      size_in_use <= pwdata[4:0];
    end
  end

  // Dimension in use, clamped to the supported range.
  always_comb begin
    if (size_in_use == 5'd0) begin
      n = DIM_W'(1);
    end else if ({1'b0, size_in_use} > 6'(MAX_SIZE)) begin
      n = DIM_W'(MAX_SIZE);
    end else begin
      n = DIM_W'(size_in_use);
    end
  end

  lupds_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .row       (row),
    .column    (column),
    .last      (last),
    .n         (n),
    .cfg_we    (cfg_we),
    .stat      (stat),
    .cmd       (cmd)
  );

  lupds_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .element_value (element_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .kind          (kind),
    .index         (index),
    .result_value  (result_value),
    .singular      (singular),
    .last_res      (last_res)
  );

endmodule

// ===== hdl/lupds_mul.sv =====
// Q32.32 multiplier built from four 32 by 32 partial products, taken one after another.
module lupds_mul (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] res
);
  import lupds_pkg::*;

  logic         busy;
  logic [2:0]   cnt;
  logic         neg;
  logic [63:0]  ma;
  logic [63:0]  mb;
  logic [63:0]  pp;
  logic [1:0]   pps;
  logic [127:0] acc;
  logic [31:0]  opa;
  logic [31:0]  opb;
  logic [63:0]  prod;
  logic [127:0] ppx;

  // Select the halves for this partial product.
  always_comb begin
    case (cnt[1:0])
      2'd0: begin
        opa = ma[31:0];
        opb = mb[31:0];
      end
      2'd1: begin
        opa = ma[31:0];
        opb = mb[63:32];
      end
      2'd2: begin
        opa = ma[63:32];
        opb = mb[31:0];
      end
      default: begin
        opa = ma[63:32];
        opb = mb[63:32];
      end
    endcase
  end

  assign prod = {32'd0, opa} * {32'd0, opb};

  // Align the registered partial product to its weight.
  always_comb begin
    case (pps)
      2'd0:    ppx = {64'd0, pp};
      2'd3:    ppx = {pp, 64'd0};
      default: ppx = {32'd0, pp, 32'd0};
    endcase
  end

  // Sequencing of the unit.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 3'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 3'd0;
      end else if (busy) begin
        cnt <= cnt + 3'd1;
        if (cnt == 3'd5) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Operands, partial products and accumulation.
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= a[63] ^ b[63];
      ma  <= mag64(a);
      mb  <= mag64(b);
      acc <= 128'd0;
    end else if (busy) begin
      if (cnt < 3'd4) begin
        pp  <= prod;
        pps <= cnt[1:0];
      end
      if (cnt >= 3'd1 && cnt <= 3'd4) begin
        acc <= acc + ppx;
      end
      if (cnt == 3'd5) begin
        res <= sat_signed(acc[95:32], neg, |acc[127:96]);
      end
    end
  end

endmodule

// ===== hdl/lupds_div.sv =====
// Q32.32 divider, restoring, one quotient bit per cycle.
module lupds_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] res,
  output logic        err
);
  import lupds_pkg::*;

  logic        busy;
  logic [6:0]  cnt;
  logic        zb;
  logic        neg;
  logic [63:0] mb;
  logic [95:0] num;
  logic [64:0] r;
  logic [95:0] q;
  logic [64:0] rs;
  logic        ge;

  assign rs = {r[63:0], num[95]};
  assign ge = rs >= {1'b0, mb};

  // Sequencing of the unit.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 7'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 7'd0;
      end else if (busy) begin
        cnt <= cnt + 7'd1;
        if (zb || cnt == 7'd96) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift-subtract steps and the final saturation.
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= a[63] ^ b[63];
      mb  <= mag64(b);
      zb  <= (mag64(b) == 64'd0);
      num <= {mag64(a), 32'd0};
      r   <= 65'd0;
      q   <= 96'd0;
    end else if (busy) begin
      if (zb) begin
        res <= 64'd0;
        err <= 1'b1;
      end else if (cnt == 7'd96) begin
        res <= sat_signed(q[63:0], neg, |q[95:64]);
        err <= 1'b0;
      end else begin
        r   <= ge ? (rs - {1'b0, mb}) : rs;
        q   <= {q[94:0], ge};
        num <= {num[94:0], 1'b0};
      end
    end
  end

endmodule

// ===== hdl/lupds_dp.sv =====
// Datapath: matrix memory, vectors, arithmetic units and the result register.
module lupds_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  lupds_pkg::dp_cmd_t   cmd,
  output lupds_pkg::dp_stat_t  stat,
  input  logic signed [63:0]   element_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 kind,
  output logic [3:0]           index,
  output logic signed [63:0]   result_value,
  output logic                 singular,
  output logic                 last_res
);
  import lupds_pkg::*;

  logic [63:0] mem [MAX_SIZE*MAX_SIZE];
  logic [63:0] xv  [MAX_SIZE];
  logic [63:0] rhs [MAX_SIZE];
  logic [63:0] rdata;
  logic [63:0] best;
  logic [63:0] tmp;
  logic [63:0] piv;
  logic [63:0] f;
  logic [63:0] cur;
  logic [63:0] acc;
  logic        fsing;
  logic        serr;

  logic              we;
  logic [MEM_AW-1:0] waddr;
  logic [MEM_AW-1:0] raddr;
  logic [63:0]       wdata;
  logic [63:0]       xsel;
  logic [63:0]       rdmag;
  logic              out_free;

  logic        mul_start;
  logic [63:0] mul_a;
  logic        mul_done;
  logic [63:0] mul_res;
  logic        div_start;
  logic [63:0] div_a;
  logic [63:0] div_b;
  logic        div_done;
  logic [63:0] div_res;
  logic        div_err;

  assign xsel     = xv[cmd.xidx];
  assign rdmag    = mag64(rdata);
  assign out_free = !out_valid || !out_stall;
  assign raddr    = {cmd.rd_row, cmd.rd_col};
  assign waddr    = {cmd.wr_row, cmd.wr_col};

  assign stat.mul_done  = mul_done;
  assign stat.div_done  = div_done;
  assign stat.best_gt   = rdmag > best;
  assign stat.best_zero = (best == 64'd0);
  assign stat.out_free  = out_free;

  // Matrix write port selection.
  always_comb begin
    we    = 1'b0;
    wdata = rdata;
    case (cmd.op)
      DP_LOAD_M: begin
        we    = 1'b1;
        wdata = element_value;
      end
      DP_WR_RDATA: we = 1'b1;
      DP_WR_TMP: begin
        we    = 1'b1;
        wdata = tmp;
      end
      DP_WR_F: begin
        we    = 1'b1;
        wdata = div_res;
      end
      DP_WR_UPD: begin
        we    = 1'b1;
        wdata = ssub(cur, mul_res);
      end
      default: we = 1'b0;
    endcase
  end

  // Operands of the shared units.
  assign mul_start = (cmd.op == DP_MUL_F) || (cmd.op == DP_MUL_X);
  assign mul_a     = (cmd.op == DP_MUL_F) ? f : xsel;
  assign div_start = (cmd.op == DP_DIV_F) || (cmd.op == DP_DIV_B);
  assign div_a     = (cmd.op == DP_DIV_F) ? rdata : ssub(xsel, acc);
  assign div_b     = (cmd.op == DP_DIV_F) ? piv : rdata;

  lupds_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (rdata),
    .done  (mul_done),
    .res   (mul_res)
  );

  lupds_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .a     (div_a),
    .b     (div_b),
    .done  (div_done),
    .res   (div_res),
    .err   (div_err)
  );

  // Matrix memory with a registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // Working registers and vectors.
  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_LOAD_R:   rhs[cmd.wr_row] <= element_value;
      DP_BEST_CLR: best <= 64'd0;
      DP_BEST_CMP: begin
        if (rdmag > best) begin
          best <= rdmag;
        end
      end
      DP_TMP_CAP:  tmp <= rdata;
      DP_PIV_CAP:  piv <= rdata;
      DP_WR_F:     f <= div_res;
      DP_CUR_CAP:  cur <= rdata;
      DP_ACC_CLR:  acc <= 64'd0;
      DP_ACC_ADD:  acc <= sadd(acc, mul_res);
      DP_FWD_WR:   xv[cmd.xidx] <= ssub(rhs[cmd.ridx], acc);
      DP_SOL_WR:   xv[cmd.xidx] <= div_res;
      default: ;
    endcase
  end

  // Singular flags for factoring and for the solve.
  always_ff @(posedge clk) begin
    if (rst) begin
      fsing <= 1'b0;
      serr  <= 1'b0;
    end else begin
      case (cmd.op)
        DP_FSING_CLR: fsing <= 1'b0;
        DP_FSING_SET: fsing <= 1'b1;
        DP_WR_F: begin
          if (div_err) begin
            fsing <= 1'b1;
          end
        end
        DP_SERR_CLR: serr <= 1'b0;
        DP_SOL_WR: begin
          if (div_err) begin
            serr <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Result register; holds while the receiver stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((cmd.op == DP_EMIT_STAT || cmd.op == DP_EMIT_SOL) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (cmd.op == DP_EMIT_STAT) begin
        kind         <= 1'b0;
        index        <= 4'd0;
        result_value <= 64'sd0;
        singular     <= cmd.force_sing | fsing;
        last_res     <= 1'b1;
      end else if (cmd.op == DP_EMIT_SOL) begin
        kind         <= 1'b1;
        index        <= cmd.res_index;
        result_value <= xsel;
        singular     <= fsing | serr;
        last_res     <= cmd.res_last;
      end
    end
  end

endmodule

// ===== hdl/lupds_ctrl.sv =====
// Sequencer for loading, factoring, substitution and result delivery.
module lupds_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          operation,
  input  logic [3:0]                    row,
  input  logic [3:0]                    column,
  input  logic                          last,
  input  logic [lupds_pkg::DIM_W-1:0]   n,
  input  logic                          cfg_we,
  input  lupds_pkg::dp_stat_t           stat,
  output lupds_pkg::dp_cmd_t            cmd
);
  import lupds_pkg::*;

  typedef enum logic [5:0] {
    IDLE, F_INIT, P_START, P_RD, P_CMP, P_DEC, PM0, PM1, PM2,
    SW0, SW1, SW2, SW3, E_START, E_PIV, E_ROW, E_RDL, E_DIV, E_DIVW,
    U_CHK, U_RDK, U_MUL, U_CUR, U_WAIT, K_NEXT, EMIT_F, EMIT_U,
    S_INIT, FW_ROW, FW_CHK, FW_RD, FW_MUL, FW_WAIT, FW_WR,
    BK_INIT, BK_ROW, BK_CHK, BK_RD, BK_MUL, BK_WAIT, BK_RDD, BK_DIV, BK_DW,
    EM_INIT, EM
  } state_t;

  state_t           state;
  logic [DIM_W-1:0] k;
  logic [DIM_W-1:0] i;
  logic [DIM_W-1:0] j;
  logic [DIM_W-1:0] bi;
  logic [IDX_W-1:0] piv;
  logic [IDX_W-1:0] ptmp;
  logic [IDX_W-1:0] perm [MAX_SIZE];
  logic [IDX_W-1:0] pr_addr;
  logic [IDX_W-1:0] prd;
  logic             fact;
  logic             accept;
  logic             row_ok;
  logic             col_ok;

  assign in_stall = (state != IDLE);
  assign accept   = in_valid && (state == IDLE);
  assign row_ok   = {1'b0, row} < n;
  assign col_ok   = {1'b0, column} < n;
  assign bi       = i - 1'b1;

  // Single read point of the permutation.
  always_comb begin
    case (state)
      PM1:     pr_addr = piv;
      FW_WR:   pr_addr = i[IDX_W-1:0];
      default: pr_addr = k[IDX_W-1:0];
    endcase
  end
  assign prd = perm[pr_addr];

  // Commands to the datapath.
  always_comb begin
    cmd = '0;
    cmd.op = DP_NOP;
    case (state)
      IDLE: begin
        cmd.wr_row = row;
        cmd.wr_col = column;
        if (accept) begin
          if (!operation && row_ok && col_ok) begin
            cmd.op = DP_LOAD_M;
          end else if (operation && row_ok) begin
            cmd.op = DP_LOAD_R;
          end
        end
      end
      F_INIT:  cmd.op = DP_FSING_CLR;
      P_START: cmd.op = DP_BEST_CLR;
      P_RD: begin
        cmd.rd_row = i[IDX_W-1:0];
        cmd.rd_col = k[IDX_W-1:0];
      end
      P_CMP: cmd.op = DP_BEST_CMP;
      P_DEC: begin
        if (stat.best_zero) begin
          cmd.op = DP_FSING_SET;
        end
      end
      SW0: begin
        cmd.rd_row = k[IDX_W-1:0];
        cmd.rd_col = j[IDX_W-1:0];
      end
      SW1: begin
        cmd.op     = DP_TMP_CAP;
        cmd.rd_row = piv;
        cmd.rd_col = j[IDX_W-1:0];
      end
      SW2: begin
        cmd.op     = DP_WR_RDATA;
        cmd.wr_row = k[IDX_W-1:0];
        cmd.wr_col = j[IDX_W-1:0];
      end
      SW3: begin
        cmd.op     = DP_WR_TMP;
        cmd.wr_row = piv;
        cmd.wr_col = j[IDX_W-1:0];
      end
      E_START: begin
        cmd.rd_row = k[IDX_W-1:0];
        cmd.rd_col = k[IDX_W-1:0];
      end
      E_PIV: cmd.op = DP_PIV_CAP;
      E_RDL: begin
        cmd.rd_row = i[IDX_W-1:0];
        cmd.rd_col = k[IDX_W-1:0];
      end
      E_DIV: cmd.op = DP_DIV_F;
      E_DIVW: begin
        cmd.wr_row = i[IDX_W-1:0];
        cmd.wr_col = k[IDX_W-1:0];
        if (stat.div_done) begin
          cmd.op = DP_WR_F;
        end
      end
      U_RDK: begin
        cmd.rd_row = k[IDX_W-1:0];
        cmd.rd_col = j[IDX_W-1:0];
      end
      U_MUL: begin
        cmd.op     = DP_MUL_F;
        cmd.rd_row = i[IDX_W-1:0];
        cmd.rd_col = j[IDX_W-1:0];
      end
      U_CUR: cmd.op = DP_CUR_CAP;
      U_WAIT: begin
        cmd.wr_row = i[IDX_W-1:0];
        cmd.wr_col = j[IDX_W-1:0];
        if (stat.mul_done) begin
          cmd.op = DP_WR_UPD;
        end
      end
      EMIT_F: cmd.op = DP_EMIT_STAT;
      EMIT_U: begin
        cmd.op         = DP_EMIT_STAT;
        cmd.force_sing = 1'b1;
      end
      S_INIT: cmd.op = DP_SERR_CLR;
      FW_ROW: begin
        if (i < n) begin
          cmd.op = DP_ACC_CLR;
        end
      end
      FW_RD: begin
        cmd.rd_row = i[IDX_W-1:0];
        cmd.rd_col = j[IDX_W-1:0];
      end
      FW_MUL: begin
        cmd.op   = DP_MUL_X;
        cmd.xidx = j[IDX_W-1:0];
      end
      FW_WAIT: begin
        if (stat.mul_done) begin
          cmd.op = DP_ACC_ADD;
        end
      end
      FW_WR: begin
        cmd.op   = DP_FWD_WR;
        cmd.xidx = i[IDX_W-1:0];
        cmd.ridx = prd;
      end
      BK_ROW: begin
        if (i != '0) begin
          cmd.op = DP_ACC_CLR;
        end
      end
      BK_RD: begin
        cmd.rd_row = bi[IDX_W-1:0];
        cmd.rd_col = j[IDX_W-1:0];
      end
      BK_MUL: begin
        cmd.op   = DP_MUL_X;
        cmd.xidx = j[IDX_W-1:0];
      end
      BK_WAIT: begin
        if (stat.mul_done) begin
          cmd.op = DP_ACC_ADD;
        end
      end
      BK_RDD: begin
        cmd.rd_row = bi[IDX_W-1:0];
        cmd.rd_col = bi[IDX_W-1:0];
      end
      BK_DIV: begin
        cmd.op   = DP_DIV_B;
        cmd.xidx = bi[IDX_W-1:0];
      end
      BK_DW: begin
        cmd.xidx = bi[IDX_W-1:0];
        if (stat.div_done) begin
          cmd.op = DP_SOL_WR;
        end
      end
      EM: begin
        cmd.op        = DP_EMIT_SOL;
        cmd.xidx      = i[IDX_W-1:0];
        cmd.res_index = i[IDX_W-1:0];
        cmd.res_last  = (i + 1'b1 == n);
      end
      default: cmd.op = DP_NOP;
    endcase
  end

  // State, loop counters, permutation and the factored flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      k     <= '0;
      i     <= '0;
      j     <= '0;
      piv   <= '0;
      ptmp  <= '0;
      fact  <= 1'b0;
      for (int p = 0; p < MAX_SIZE; p++) begin
        perm[p] <= IDX_W'(p);
      end
    end else begin
      if (cfg_we) begin
        fact <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (accept) begin
            if (!operation) begin
              fact <= 1'b0;
              if (last) begin
                state <= F_INIT;
              end
            end else if (last) begin
              state <= fact ? S_INIT : EMIT_U;
            end
          end
        end
        F_INIT: begin
          for (int p = 0; p < MAX_SIZE; p++) begin
            perm[p] <= IDX_W'(p);
          end
          k     <= '0;
          state <= P_START;
        end
        P_START: begin
          i     <= k;
          piv   <= k[IDX_W-1:0];
          state <= P_RD;
        end
        P_RD: state <= P_CMP;
        P_CMP: begin
          if (stat.best_gt) begin
            piv <= i[IDX_W-1:0];
          end
          if (i + 1'b1 < n) begin
            i     <= i + 1'b1;
            state <= P_RD;
          end else begin
            state <= P_DEC;
          end
        end
        P_DEC: begin
          if (!stat.best_zero && piv != k[IDX_W-1:0]) begin
            state <= PM0;
          end else begin
            state <= E_START;
          end
        end
        PM0: begin
          ptmp  <= prd;
          state <= PM1;
        end
        PM1: begin
          perm[k[IDX_W-1:0]] <= prd;
          state <= PM2;
        end
        PM2: begin
          perm[piv] <= ptmp;
          j     <= '0;
          state <= SW0;
        end
        SW0: state <= SW1;
        SW1: state <= SW2;
        SW2: state <= SW3;
        SW3: begin
          if (j + 1'b1 < n) begin
            j     <= j + 1'b1;
            state <= SW0;
          end else begin
            state <= E_START;
          end
        end
        E_START: begin
          i     <= k + 1'b1;
          state <= E_PIV;
        end
        E_PIV: state <= E_ROW;
        E_ROW: state <= (i < n) ? E_RDL : K_NEXT;
        E_RDL: state <= E_DIV;
        E_DIV: state <= E_DIVW;
        E_DIVW: begin
          if (stat.div_done) begin
            j     <= k + 1'b1;
            state <= U_CHK;
          end
        end
        U_CHK: begin
          if (j < n) begin
            state <= U_RDK;
          end else begin
            i     <= i + 1'b1;
            state <= E_ROW;
          end
        end
        U_RDK: state <= U_MUL;
        U_MUL: state <= U_CUR;
        U_CUR: state <= U_WAIT;
        U_WAIT: begin
          if (stat.mul_done) begin
            j     <= j + 1'b1;
            state <= U_CHK;
          end
        end
        K_NEXT: begin
          if (k + 1'b1 < n) begin
            k     <= k + 1'b1;
            state <= P_START;
          end else begin
            fact  <= 1'b1;
            state <= EMIT_F;
          end
        end
        EMIT_F, EMIT_U: begin
          if (stat.out_free) begin
            state <= IDLE;
          end
        end
        S_INIT: begin
          i     <= '0;
          state <= FW_ROW;
        end
        FW_ROW: begin
          j     <= '0;
          state <= (i < n) ? FW_CHK : BK_INIT;
        end
        FW_CHK: state <= (j < i) ? FW_RD : FW_WR;
        FW_RD:  state <= FW_MUL;
        FW_MUL: state <= FW_WAIT;
        FW_WAIT: begin
          if (stat.mul_done) begin
            j     <= j + 1'b1;
            state <= FW_CHK;
          end
        end
        FW_WR: begin
          i     <= i + 1'b1;
          state <= FW_ROW;
        end
        BK_INIT: begin
          i     <= n;
          state <= BK_ROW;
        end
        BK_ROW: begin
          j     <= i;
          state <= (i != '0) ? BK_CHK : EM_INIT;
        end
        BK_CHK: state <= (j < n) ? BK_RD : BK_RDD;
        BK_RD:  state <= BK_MUL;
        BK_MUL: state <= BK_WAIT;
        BK_WAIT: begin
          if (stat.mul_done) begin
            j     <= j + 1'b1;
            state <= BK_CHK;
          end
        end
        BK_RDD: state <= BK_DIV;
        BK_DIV: state <= BK_DW;
        BK_DW: begin
          if (stat.div_done) begin
            i     <= bi;
            state <= BK_ROW;
          end
        end
        EM_INIT: begin
          i     <= '0;
          state <= EM;
        end
        EM: begin
          if (stat.out_free) begin
            if (i + 1'b1 == n) begin
              state <= IDLE;
            end else begin
              i <= i + 1'b1;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule
